/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define SVA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define SVA_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define SVA_ASSERT(label, clk, rstn, prop, msg)
`define SVA_NEVER(label, clk, rstn, expr, msg)
`endif

`endif

/* hw/rtl/pva_pkg.sv */
// Shared types, codes and constants of the polyphonic voice allocator.
package pva_pkg;

    // Default slot count and command queue depth
    localparam int VOICE_COUNT_DEF = 16;
    localparam int CMD_QUEUE_DEPTH = 4;
    // Cap on results reported for one input
    localparam int MAX_RESULTS     = 16;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int SLOT_W   = 4;
    localparam int ACTION_W = 3;
    localparam int COUNT_W  = 5;
    localparam int MODE_W   = 3;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_NOTE_ON    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEDAL_DOWN = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PEDAL_UP   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ALL_OFF    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FINISHED   = 3'd5;

    // Result action codes
    localparam logic [ACTION_W-1:0] ACT_FREED   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RETRIG  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_STEAL   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_HELD    = 3'd5;

    // Steal policy codes; other values fall back to oldest
    localparam logic [MODE_W-1:0] MODE_OLDEST   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOWEST   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIGHEST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RROBIN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUIETEST = 3'd4;

    // Decoded command kinds
    typedef enum logic [2:0] {
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_PEDAL_DOWN,
        OP_PEDAL_UP,
        OP_ALL_OFF,
        OP_FINISH
    } op_t;

    // One queued command
    typedef struct packed {
        op_t               op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [SLOT_W-1:0] fin;
    } cmd_t;

endpackage

/* hw/rtl/polyphonic_voice_allocator_top.sv */
// Top level of the polyphonic voice allocator: front end, command queue and slot engine.
//
// Commands enter through a decoding register and a four-entry queue, so a burst of
// inputs is taken while the slot engine works and while a result waits at the output.
// The engine reads the voice table through one port, one slot per clock: note on and a
// matching note off go through dequeue, scan, decide and report, a note off that
// matches nothing through all but the report; pedal up and all off sweep the slots up
// to the last one reported; voice finished is dequeued and reported, or only dequeued
// when the slot is already idle, and pedal down only dequeued; a stalled result channel
// holds the report and the sweep. Results of one input come out in slot order, at most
// sixteen of them, the final one marked by m_last. priority_mode may be written through
// the cfg channel only while the block is idle.
module polyphonic_voice_allocator_top import pva_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF,
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MODE_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [NOTE_W-1:0]   s_note_number,
    input  logic [VEL_W-1:0]    s_note_velocity,
    input  logic [SLOT_W-1:0]   s_finished_voice,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [ACTION_W-1:0] m_action,
    output logic [NOTE_W-1:0]   m_slot_note,
    output logic [VEL_W-1:0]    m_slot_velocity,
    output logic [COUNT_W-1:0]  m_active_count,
    output logic                m_last
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    pva_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_note_number    (s_note_number),
        .s_note_velocity  (s_note_velocity),
        .s_finished_voice (s_finished_voice),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_cmd         (push_cmd)
    );

    pva_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    pva_engine #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .q_valid         (pop_valid),
        .q_ready         (pop_ready),
        .q_cmd           (pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot          (m_slot),
        .m_action        (m_action),
        .m_slot_note     (m_slot_note),
        .m_slot_velocity (m_slot_velocity),
        .m_active_count  (m_active_count),
        .m_last          (m_last)
    );

endmodule

/* hw/rtl/pva_front.sv */
// Front end: accepts input beats, decodes the function and drops unused codes.
module pva_front import pva_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [NOTE_W-1:0] s_note_number,
    input  logic [VEL_W-1:0]  s_note_velocity,
    input  logic [SLOT_W-1:0] s_finished_voice,
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    logic dec_known;
    op_t  dec_op;
    logic accept;

    // Classify the function code
    always_comb begin
        dec_known = 1'b1;
        dec_op    = OP_NOTE_ON;
        case (s_func)
            FUNC_NOTE_ON:    dec_op = OP_NOTE_ON;
            FUNC_NOTE_OFF:   dec_op = OP_NOTE_OFF;
            FUNC_PEDAL_DOWN: dec_op = OP_PEDAL_DOWN;
            FUNC_PEDAL_UP:   dec_op = OP_PEDAL_UP;
            FUNC_ALL_OFF:    dec_op = OP_ALL_OFF;
            FUNC_FINISHED:   dec_op = OP_FINISH;
            default:         dec_known = 1'b0;
        endcase
    end

    assign s_ready    = !valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = valid_reg;
    assign push_cmd   = cmd_reg;

    // Hold a decoded beat until the queue takes it; unused codes vanish here
    always_comb begin
        if (accept && dec_known) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && dec_known) begin
            cmd_reg.op   <= dec_op;
            cmd_reg.note <= s_note_number;
            cmd_reg.vel  <= s_note_velocity;
            cmd_reg.fin  <= s_finished_voice;
        end
    end

endmodule

/* hw/rtl/pva_cmd_fifo.sv */
// Short command queue between the front end and the slot engine.
module pva_cmd_fifo import pva_pkg::*; #(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/pva_engine.sv */
// Slot engine: owns the voice table, scans it for note on and note off and emits result beats.
`include "assert_macros.svh"

module pva_engine import pva_pkg::*; #(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [MODE_W-1:0]   cfg_data,
    input  logic                q_valid,
    output logic                q_ready,
    input  cmd_t                q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [ACTION_W-1:0] m_action,
    output logic [NOTE_W-1:0]   m_slot_note,
    output logic [VEL_W-1:0]    m_slot_velocity,
    output logic [COUNT_W-1:0]  m_active_count,
    output logic                m_last
);

    localparam int IDX_W = $clog2(VOICE_COUNT);
    localparam int CNT_W = $clog2(VOICE_COUNT + 1);
    localparam int RC_W  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_SWEEP
    } state_t;

    function automatic logic better(input logic [NOTE_W-1:0] v, input logic [NOTE_W-1:0] b,
                                    input logic low);
        return low ? (v < b) : (v > b);
    endfunction

    state_t                 state_reg;
    cmd_t                   cmd_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [VOICE_COUNT-1:0] active_reg;
    logic [VOICE_COUNT-1:0] rel_reg;
    logic [VOICE_COUNT-1:0] held_reg;
    logic [NOTE_W-1:0]      note_mem [VOICE_COUNT];
    logic [VEL_W-1:0]       vel_mem  [VOICE_COUNT];
    logic [IDX_W-1:0]       rotate_reg;
    logic                   pedal_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [VOICE_COUNT-1:0] mask_reg;
    logic [RC_W-1:0]        rcount_reg;
    logic [ACTION_W-1:0]    res_action_reg;

    // Scan trackers
    logic                   match_found_reg;
    logic [IDX_W-1:0]       match_idx_reg;
    logic                   free_found_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   rel_found_reg;
    logic [IDX_W-1:0]       rel_idx_reg;
    logic                   rot_found_reg;
    logic [IDX_W-1:0]       rot_idx_reg;
    logic                   xrel_found_reg;
    logic [IDX_W-1:0]       xrel_idx_reg;
    logic [NOTE_W-1:0]      xrel_val_reg;
    logic                   xall_found_reg;
    logic [IDX_W-1:0]       xall_idx_reg;
    logic [NOTE_W-1:0]      xall_val_reg;

    // Output register
    logic                   m_valid_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic [ACTION_W-1:0]    m_action_reg;
    logic [NOTE_W-1:0]      m_note_reg;
    logic [VEL_W-1:0]       m_vel_reg;
    logic [COUNT_W-1:0]     m_count_reg;
    logic                   m_last_reg;

    logic [NOTE_W-1:0]      rd_note;
    logic [VEL_W-1:0]       rd_vel;
    logic                   rd_act;
    logic                   rd_rel;
    logic [NOTE_W-1:0]      ext_val;
    logic                   want_low;
    logic                   scan_last;
    logic                   fin_ok;
    logic [IDX_W-1:0]       fin_idx;
    logic [VOICE_COUNT-1:0] sweep_mask;
    logic [VOICE_COUNT-1:0] mask_clr;
    logic                   sweep_last;
    logic                   out_free;
    logic                   emit_fire;
    logic [ACTION_W-1:0]    emit_action;
    logic                   emit_last;
    logic [COUNT_W-1:0]     count_sat;
    logic [IDX_W-1:0]       victim;
    logic [IDX_W-1:0]       target;
    logic [ACTION_W-1:0]    target_action;
    logic                   wr_en;

    assign cfg_ready = 1'b1;
    assign q_ready   = (state_reg == ST_IDLE);

    // Single read port at the scan or report index
    assign rd_note   = note_mem[idx_reg];
    assign rd_vel    = vel_mem[idx_reg];
    assign rd_act    = active_reg[idx_reg];
    assign rd_rel    = rel_reg[idx_reg];
    assign want_low  = (mode_reg != MODE_HIGHEST);
    assign ext_val   = (mode_reg == MODE_QUIETEST) ? rd_vel : rd_note;
    assign scan_last = (idx_reg == IDX_W'(VOICE_COUNT - 1));

    // Voice-finished range check
    assign fin_ok  = (32'(q_cmd.fin) < 32'(VOICE_COUNT));
    assign fin_idx = IDX_W'(q_cmd.fin);

    assign sweep_mask = (q_cmd.op == OP_ALL_OFF) ? active_reg : (active_reg & held_reg);

    // Sweep bookkeeping: last on the final set bit or on the result cap
    always_comb begin
        mask_clr          = mask_reg;
        mask_clr[idx_reg] = 1'b0;
    end
    assign sweep_last = (mask_clr == '0) || (rcount_reg == RC_W'(MAX_RESULTS - 1));

    // Result emission
    assign out_free    = !m_valid_reg || m_ready;
    assign emit_fire   = out_free && ((state_reg == ST_EMIT) ||
                                      ((state_reg == ST_SWEEP) && mask_reg[idx_reg]));
    assign emit_action = (state_reg == ST_EMIT) ? res_action_reg : ACT_RELEASE;
    assign emit_last   = (state_reg == ST_EMIT) ? 1'b1 : sweep_last;
    assign count_sat   = (32'(count_reg) > 32'd31) ? COUNT_W'(31) : COUNT_W'(count_reg);

    // Steal victim by policy; every policy prefers a releasing slot
    always_comb begin
        case (mode_reg)
            MODE_LOWEST, MODE_HIGHEST: begin
                victim = xrel_found_reg ? xrel_idx_reg :
                         (xall_found_reg ? xall_idx_reg : '0);
            end
            MODE_RROBIN: begin
                victim = rot_found_reg ? rot_idx_reg :
                         (rel_found_reg ? rel_idx_reg : rotate_reg);
            end
            MODE_QUIETEST: begin
                victim = rel_found_reg ? rel_idx_reg :
                         (xall_found_reg ? xall_idx_reg : '0);
            end
            default: begin
                victim = rel_found_reg ? rel_idx_reg : '0;
            end
        endcase
    end

    // Note-on target: retrigger, then first free, then steal
    always_comb begin
        if (match_found_reg) begin
            target        = match_idx_reg;
            target_action = ACT_RETRIG;
        end else if (free_found_reg) begin
            target        = free_idx_reg;
            target_action = ACT_START;
        end else begin
            target        = victim;
            target_action = ACT_STEAL;
        end
    end

    assign wr_en = (state_reg == ST_DECIDE) && (cmd_reg.op == OP_NOTE_ON);

    // Sequencer, slot flags and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_OLDEST;
            active_reg      <= '0;
            rel_reg         <= '0;
            held_reg        <= '0;
            rotate_reg      <= '0;
            pedal_reg       <= 1'b0;
            count_reg       <= '0;
            idx_reg         <= '0;
            mask_reg        <= '0;
            rcount_reg      <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            rel_found_reg   <= 1'b0;
            rot_found_reg   <= 1'b0;
            xrel_found_reg  <= 1'b0;
            xall_found_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end

            // Load the output register on emission, drop it once taken
            if (emit_fire) begin
                m_valid_reg  <= 1'b1;
                m_slot_reg   <= SLOT_W'(idx_reg);
                m_action_reg <= emit_action;
                m_note_reg   <= rd_note;
                m_vel_reg    <= rd_vel;
                m_count_reg  <= count_sat;
                m_last_reg   <= emit_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        case (q_cmd.op)
                            OP_NOTE_ON, OP_NOTE_OFF: begin
                                cmd_reg         <= q_cmd;
                                idx_reg         <= '0;
                                match_found_reg <= 1'b0;
                                free_found_reg  <= 1'b0;
                                rel_found_reg   <= 1'b0;
                                rot_found_reg   <= 1'b0;
                                xrel_found_reg  <= 1'b0;
                                xall_found_reg  <= 1'b0;
                                state_reg       <= ST_SCAN;
                            end
                            OP_PEDAL_DOWN: begin
                                pedal_reg <= 1'b1;
                            end
                            OP_PEDAL_UP, OP_ALL_OFF: begin
                                pedal_reg <= 1'b0;
                                if (sweep_mask != '0) begin
                                    rel_reg    <= rel_reg | sweep_mask;
                                    held_reg   <= held_reg & ~sweep_mask;
                                    mask_reg   <= sweep_mask;
                                    idx_reg    <= '0;
                                    rcount_reg <= '0;
                                    state_reg  <= ST_SWEEP;
                                end
                            end
                            OP_FINISH: begin
                                if (fin_ok && active_reg[fin_idx]) begin
                                    active_reg[fin_idx] <= 1'b0;
                                    rel_reg[fin_idx]    <= 1'b0;
                                    held_reg[fin_idx]   <= 1'b0;
                                    count_reg           <= count_reg - CNT_W'(1);
                                    idx_reg             <= fin_idx;
                                    res_action_reg      <= ACT_FREED;
                                    state_reg           <= ST_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // Visit one slot per cycle and update every tracker
                ST_SCAN: begin
                    if (rd_act && (rd_note == cmd_reg.note) && !match_found_reg) begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= idx_reg;
                    end
                    if (!rd_act && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    if (rd_act && rd_rel && !rel_found_reg) begin
                        rel_found_reg <= 1'b1;
                        rel_idx_reg   <= idx_reg;
                    end
                    if (rd_act && rd_rel && (idx_reg >= rotate_reg) && !rot_found_reg) begin
                        rot_found_reg <= 1'b1;
                        rot_idx_reg   <= idx_reg;
                    end
                    if (rd_act && rd_rel &&
                        (!xrel_found_reg || better(ext_val, xrel_val_reg, want_low))) begin
                        xrel_found_reg <= 1'b1;
                        xrel_idx_reg   <= idx_reg;
                        xrel_val_reg   <= ext_val;
                    end
                    if (rd_act &&
                        (!xall_found_reg || better(ext_val, xall_val_reg, want_low))) begin
                        xall_found_reg <= 1'b1;
                        xall_idx_reg   <= idx_reg;
                        xall_val_reg   <= ext_val;
                    end
                    if (scan_last) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                // Apply the note-on or note-off outcome
                ST_DECIDE: begin
                    if (cmd_reg.op == OP_NOTE_ON) begin
                        active_reg[target] <= 1'b1;
                        rel_reg[target]    <= 1'b0;
                        held_reg[target]   <= 1'b0;
                        idx_reg            <= target;
                        res_action_reg     <= target_action;
                        if (target_action == ACT_START) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if ((target_action == ACT_STEAL) && (mode_reg == MODE_RROBIN)) begin
                            rotate_reg <= (victim == IDX_W'(VOICE_COUNT - 1)) ? '0 :
                                          victim + IDX_W'(1);
                        end
                        state_reg <= ST_EMIT;
                    end else if (match_found_reg) begin
                        idx_reg <= match_idx_reg;
                        if (pedal_reg) begin
                            held_reg[match_idx_reg] <= 1'b1;
                            res_action_reg          <= ACT_HELD;
                        end else begin
                            rel_reg[match_idx_reg]  <= 1'b1;
                            held_reg[match_idx_reg] <= 1'b0;
                            res_action_reg          <= ACT_RELEASE;
                        end
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_EMIT: begin
                    if (emit_fire) begin
                        state_reg <= ST_IDLE;
                    end
                end

                // Report released slots in index order
                ST_SWEEP: begin
                    if (!mask_reg[idx_reg]) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end else if (emit_fire) begin
                        if (sweep_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            mask_reg   <= mask_clr;
                            rcount_reg <= rcount_reg + RC_W'(1);
                            idx_reg    <= idx_reg + IDX_W'(1);
                        end
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Note and velocity stores
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            note_mem[target] <= cmd_reg.note;
            vel_mem[target]  <= cmd_reg.vel;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slot          = m_slot_reg;
    assign m_action        = m_action_reg;
    assign m_slot_note     = m_note_reg;
    assign m_slot_velocity = m_vel_reg;
    assign m_active_count  = m_count_reg;
    assign m_last          = m_last_reg;

    `SVA_ASSERT(a_count_tracks, aclk, aresetn, count_reg == $countones(active_reg), "active count out of step with active flags")
    `SVA_NEVER(a_held_active, aclk, aresetn, (held_reg & ~active_reg) != '0, "held flag on an inactive slot")
    `SVA_NEVER(a_rel_active, aclk, aresetn, (rel_reg & ~active_reg) != '0, "releasing flag on an inactive slot")
    `SVA_ASSERT(a_sweep_mask, aclk, aresetn, (state_reg == ST_SWEEP) |-> (mask_reg != '0), "sweep with no slot left to report")
    `SVA_ASSERT(a_last_idle, aclk, aresetn, (emit_fire && emit_last) |=> (state_reg == ST_IDLE), "engine busy after the final result")

endmodule

/* bench/tb_polyphonic_voice_allocator_top.sv */
`timescale 1ns / 1ps
// Testbench for the polyphonic voice allocator: directed and random voice events.
module tb_polyphonic_voice_allocator_top;
    import pva_pkg::*;

    localparam int SLOTS       = VOICE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    // Queue depth plus decode stage, each up to one full slot scan
    localparam int IDLE_TAIL   = 128;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [ACTION_W-1:0] action;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    vel;
        logic [COUNT_W-1:0]  active_count;
        logic                last;
    } voice_event_t;

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [MODE_W-1:0]   cfg_data         = '0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func           = '0;
    logic [NOTE_W-1:0]   s_note_number    = '0;
    logic [VEL_W-1:0]    s_note_velocity  = '0;
    logic [SLOT_W-1:0]   s_finished_voice = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [SLOT_W-1:0]   m_slot;
    logic [ACTION_W-1:0] m_action;
    logic [NOTE_W-1:0]   m_slot_note;
    logic [VEL_W-1:0]    m_slot_velocity;
    logic [COUNT_W-1:0]  m_active_count;
    logic                m_last;

    int err_count      = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Predicted voice table
    bit                voice_on   [SLOTS];
    bit                voice_rel  [SLOTS];
    bit                voice_hold [SLOTS];
    logic [NOTE_W-1:0] voice_note [SLOTS];
    logic [VEL_W-1:0]  voice_vel  [SLOTS];
    int                rr_next;
    bit                sustain;
    logic [MODE_W-1:0] steal_mode;

    voice_event_t step_results[$];
    voice_event_t pending_voice_events[$];

    polyphonic_voice_allocator_top #(
        .VOICE_COUNT(SLOTS)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_note_number    (s_note_number),
        .s_note_velocity  (s_note_velocity),
        .s_finished_voice (s_finished_voice),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_slot           (m_slot),
        .m_action         (m_action),
        .m_slot_note      (m_slot_note),
        .m_slot_velocity  (m_slot_velocity),
        .m_active_count   (m_active_count),
        .m_last           (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Randomly stall the result channel
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $time);
        err_count++;
    endtask

    // Check each result beat against the oldest pending expectation
    always @(posedge aclk) begin
        voice_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_voice_events.size() == 0) begin
                report_mismatch("beat with nothing pending, slot", 0, 32'(m_slot));
            end else begin
                want = pending_voice_events.pop_front();
                if (m_slot !== want.slot)
                    report_mismatch("slot", 32'(want.slot), 32'(m_slot));
                if (m_action !== want.action)
                    report_mismatch("action", 32'(want.action), 32'(m_action));
                if (m_slot_note !== want.note)
                    report_mismatch("slot_note", 32'(want.note), 32'(m_slot_note));
                if (m_slot_velocity !== want.vel)
                    report_mismatch("slot_velocity", 32'(want.vel), 32'(m_slot_velocity));
                if (m_active_count !== want.active_count)
                    report_mismatch("active_count", 32'(want.active_count),
                                    32'(m_active_count));
                if (m_last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    function automatic void stage_result(input int idx, input logic [ACTION_W-1:0] act);
        voice_event_t rec;
        if (step_results.size() < MAX_RESULTS) begin
            rec.slot         = idx[SLOT_W-1:0];
            rec.action       = act;
            rec.note         = voice_note[idx];
            rec.vel          = voice_vel[idx];
            rec.active_count = '0;
            rec.last         = 1'b0;
            step_results.push_back(rec);
        end
    endfunction

    // Pick the min or max note/velocity, releasing voices first; ties keep the lowest slot
    function automatic int pick_extreme(input bit by_velocity, input bit want_low);
        int best;
        int best_val;
        int v;
        for (int pass = 0; pass < 2; pass++) begin
            best     = -1;
            best_val = want_low ? 128 : -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!voice_on[i] || (pass == 0 && !voice_rel[i]))
                    continue;
                v = by_velocity ? int'(voice_vel[i]) : int'(voice_note[i]);
                if (want_low ? (v < best_val) : (v > best_val)) begin
                    best_val = v;
                    best     = i;
                end
            end
            if (best >= 0)
                return best;
        end
        return 0;
    endfunction

    // First releasing voice, else first active voice, scanning from slot 0 or the rotor
    function automatic int pick_first(input bit rotate);
        int start;
        int i;
        start = rotate ? rr_next : 0;
        for (int pass = 0; pass < 2; pass++) begin
            for (int k = 0; k < SLOTS; k++) begin
                i = (start + k) % SLOTS;
                if (voice_on[i] && (pass == 1 || voice_rel[i])) begin
                    if (rotate)
                        rr_next = (i + 1) % SLOTS;
                    return i;
                end
            end
        end
        if (rotate)
            rr_next = 0;
        return 0;
    endfunction

    function automatic int choose_steal_victim();
        case (steal_mode)
            MODE_LOWEST:  return pick_extreme(1'b0, 1'b1);
            MODE_HIGHEST: return pick_extreme(1'b0, 1'b0);
            MODE_RROBIN:  return pick_first(1'b1);
            MODE_QUIETEST: begin
                for (int i = 0; i < SLOTS; i++)
                    if (voice_on[i] && voice_rel[i])
                        return i;
                return pick_extreme(1'b1, 1'b1);
            end
            default:      return pick_first(1'b0);
        endcase
    endfunction

    // Update the voice table for one event and queue the result beats it causes
    task automatic predict_allocation(input logic [FUNC_W-1:0] fn, input logic [NOTE_W-1:0] note,
                                      input logic [VEL_W-1:0] vel,
                                      input logic [SLOT_W-1:0] fin);
        int                  idx;
        int                  live;
        logic [ACTION_W-1:0] act;
        voice_event_t        rec;
        step_results.delete();
        case (fn)
            FUNC_NOTE_ON: begin
                idx = -1;
                act = ACT_RETRIG;
                for (int i = 0; i < SLOTS && idx < 0; i++)
                    if (voice_on[i] && voice_note[i] == note)
                        idx = i;
                if (idx < 0) begin
                    act = ACT_START;
                    for (int i = 0; i < SLOTS && idx < 0; i++)
                        if (!voice_on[i])
                            idx = i;
                end
                if (idx < 0) begin
                    act = ACT_STEAL;
                    idx = choose_steal_victim();
                end
                voice_on[idx]   = 1'b1;
                voice_rel[idx]  = 1'b0;
                voice_hold[idx] = 1'b0;
                voice_note[idx] = note;
                voice_vel[idx]  = vel;
                stage_result(idx, act);
            end
            FUNC_NOTE_OFF: begin
                idx = -1;
                for (int i = 0; i < SLOTS && idx < 0; i++)
                    if (voice_on[i] && voice_note[i] == note)
                        idx = i;
                if (idx >= 0) begin
                    if (sustain) begin
                        voice_hold[idx] = 1'b1;
                        stage_result(idx, ACT_HELD);
                    end else begin
                        voice_rel[idx]  = 1'b1;
                        voice_hold[idx] = 1'b0;
                        stage_result(idx, ACT_RELEASE);
                    end
                end
            end
            FUNC_PEDAL_DOWN: sustain = 1'b1;
            FUNC_PEDAL_UP: begin
                sustain = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (voice_on[i] && voice_hold[i]) begin
                        voice_rel[i]  = 1'b1;
                        voice_hold[i] = 1'b0;
                        stage_result(i, ACT_RELEASE);
                    end
            end
            FUNC_ALL_OFF: begin
                for (int i = 0; i < SLOTS; i++)
                    if (voice_on[i]) begin
                        voice_rel[i]  = 1'b1;
                        voice_hold[i] = 1'b0;
                        stage_result(i, ACT_RELEASE);
                    end
                sustain = 1'b0;
            end
            FUNC_FINISHED: begin
                if (voice_on[fin]) begin
                    voice_on[fin]   = 1'b0;
                    voice_rel[fin]  = 1'b0;
                    voice_hold[fin] = 1'b0;
                    stage_result(int'(fin), ACT_FREED);
                end
            end
            default: ;
        endcase
        live = 0;
        for (int i = 0; i < SLOTS; i++)
            live += int'(voice_on[i]);
        for (int k = 0; k < step_results.size(); k++) begin
            rec              = step_results[k];
            rec.active_count = live[COUNT_W-1:0];
            rec.last         = (k == step_results.size() - 1);
            pending_voice_events.push_back(rec);
        end
    endtask

    // Send one event beat, idling first at random, and predict it on acceptance
    task automatic drive_voice_event(input logic [FUNC_W-1:0] fn, input logic [NOTE_W-1:0] note,
                                     input logic [VEL_W-1:0] vel,
                                     input logic [SLOT_W-1:0] fin);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_func           <= fn;
        s_note_number    <= note;
        s_note_velocity  <= vel;
        s_finished_voice <= fin;
        do @(posedge aclk); while (!s_ready);
        predict_allocation(fn, note, vel, fin);
    endtask

    // Drop valid, drain all expected beats, then let silent events finish
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_voice_events.size() > 0)
            @(posedge aclk);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_priority_mode(input logic [MODE_W-1:0] mode);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        steal_mode = mode;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_start_and_retrigger();
        drive_voice_event(FUNC_NOTE_ON, 7'd0, 7'd0, 4'd0);
        drive_voice_event(FUNC_NOTE_ON, 7'd127, 7'd127, 4'd0);
        drive_voice_event(FUNC_NOTE_ON, 7'd127, 7'd64, 4'd0);
        drive_voice_event(FUNC_NOTE_OFF, 7'd0, 7'd0, 4'd0);
        // releasing voice still matches and is reported again
        drive_voice_event(FUNC_NOTE_OFF, 7'd0, 7'd0, 4'd0);
        drive_voice_event(FUNC_NOTE_OFF, 7'd55, 7'd0, 4'd0);
    endtask

    task automatic test_pedal_hold();
        drive_voice_event(FUNC_PEDAL_DOWN, 7'd0, 7'd0, 4'd0);
        drive_voice_event(FUNC_NOTE_OFF, 7'd127, 7'd0, 4'd0);
        // retrigger clears the held mark
        drive_voice_event(FUNC_NOTE_ON, 7'd127, 7'd100, 4'd0);
        drive_voice_event(FUNC_NOTE_OFF, 7'd127, 7'd0, 4'd0);
        drive_voice_event(FUNC_PEDAL_UP, 7'd0, 7'd0, 4'd0);
        drive_voice_event(FUNC_PEDAL_UP, 7'd0, 7'd0, 4'd0);
    endtask

    task automatic test_finish_and_all_off();
        drive_voice_event(FUNC_FINISHED, 7'd0, 7'd0, 4'd0);
        drive_voice_event(FUNC_FINISHED, 7'd0, 7'd0, 4'd15);
        drive_voice_event(FUNC_NOTE_ON, 7'd42, 7'd85, 4'd0);
        drive_voice_event(FUNC_NOTE_ON, 7'd85, 7'd42, 4'd0);
        drive_voice_event(FUNC_PEDAL_DOWN, 7'd0, 7'd0, 4'd0);
        drive_voice_event(FUNC_ALL_OFF, 7'd0, 7'd0, 4'd0);
        // all off lifted the pedal, so this releases instead of holding
        drive_voice_event(FUNC_NOTE_OFF, 7'd42, 7'd0, 4'd0);
        drive_voice_event(FUNC_FINISHED, 7'd0, 7'd0, 4'd1);
    endtask

    task automatic test_unused_funcs();
        drive_voice_event(FUNC_SPARE_FIRST, 7'd127, 7'd127, 4'd15);
        drive_voice_event(FUNC_SPARE_LAST, 7'h55, 7'h2A, 4'd10);
    endtask

    // Random playing under one steal policy and one idling pattern
    task automatic test_random_play(input logic [MODE_W-1:0] mode, input int send_pct,
                                    input int recv_pct, input int n_events);
        int                sent;
        int                roll;
        int                live[$];
        int                fading[$];
        logic [FUNC_W-1:0] fn;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [SLOT_W-1:0] fin;
        settle_block();
        write_priority_mode(mode);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_events) begin
            live.delete();
            fading.delete();
            for (int i = 0; i < SLOTS; i++) begin
                if (voice_on[i])
                    live.push_back(i);
                if (voice_on[i] && voice_rel[i])
                    fading.push_back(i);
            end
            roll = $urandom_range(99);
            note = NOTE_W'($urandom_range(127));
            vel  = VEL_W'($urandom_range(127));
            fin  = SLOT_W'($urandom_range(SLOTS - 1));
            if (roll < 45) begin
                fn = FUNC_NOTE_ON;
                // narrow note window to provoke retriggers
                if ($urandom_range(9) < 3)
                    note = NOTE_W'(60 + $urandom_range(7));
            end else if (roll < 65) begin
                fn = FUNC_NOTE_OFF;
                if (live.size() > 0 && $urandom_range(9) < 8)
                    note = voice_note[live[$urandom_range(live.size() - 1)]];
            end else if (roll < 71) begin
                fn = FUNC_PEDAL_DOWN;
            end else if (roll < 77) begin
                fn = FUNC_PEDAL_UP;
            end else if (roll < 80) begin
                fn = FUNC_ALL_OFF;
            end else if (roll < 96) begin
                fn = FUNC_FINISHED;
                if (fading.size() > 0 && $urandom_range(9) < 7)
                    fin = SLOT_W'(fading[$urandom_range(fading.size() - 1)]);
                else if (live.size() > 0 && $urandom_range(9) < 5)
                    fin = SLOT_W'(live[$urandom_range(live.size() - 1)]);
            end else begin
                fn = $urandom_range(1) ? FUNC_SPARE_LAST : FUNC_SPARE_FIRST;
            end
            drive_voice_event(fn, note, vel, fin);
            if (fn < FUNC_SPARE_FIRST)
                sent++;
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            voice_on[i]   = 1'b0;
            voice_rel[i]  = 1'b0;
            voice_hold[i] = 1'b0;
            voice_note[i] = '0;
            voice_vel[i]  = '0;
        end
        rr_next    = 0;
        sustain    = 1'b0;
        steal_mode = MODE_OLDEST;

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_start_and_retrigger();
        test_pedal_hold();
        test_finish_and_all_off();
        test_unused_funcs();

        test_random_play(MODE_OLDEST,      0,  0,  44);
        test_random_play(MODE_LOWEST,      59, 0,  44);
        test_random_play(MODE_HIGHEST,     0,  59, 44);
        test_random_play(MODE_RROBIN,      12, 12, 44);
        test_random_play(MODE_QUIETEST,    0,  0,  44);
        test_random_play(MODE_SPARE_LAST,  59, 0,  44);
        test_random_play(MODE_SPARE_FIRST, 0,  59, 44);
        test_random_play(MODE_SPARE_MID,   12, 12, 44);

        settle_block();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
